// ----- rtl/bresenham_line_rasterizer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_DEFINES_SVH

// Check a property outside reset.
`define BRES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BRES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bres_pkg.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer package
// Widths, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bres_pkg;

  localparam int COORD_BITS = 6;
  // Pixel count of a line runs up to 2**COORD_BITS.
  localparam int CNT_BITS   = COORD_BITS + 1;
  // Signed decision term spans about +/- 2*(2**COORD_BITS).
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } line_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ----- rtl/bres_dp.sv -----
// ----------------------------------------------------------------------------
// Bresenham datapath
// Holds the line set-up and steps the current pixel on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bres_dp (
  input  logic                 clk,
  input  bres_pkg::line_t      line,
  input  bres_pkg::dp_cmd_t    cmd,
  output bres_pkg::pixel_t     pixel,
  output bres_pkg::dp_status_t status
);

  // Move one unit along an axis: bit 0 moves, bit 1 decrements.
  function automatic bres_pkg::coord_t axis_step(bres_pkg::coord_t v, logic [1:0] sgn);
    bres_pkg::coord_t r;
    r = v;
    if (sgn[0]) begin
      r = sgn[1] ? v - 1'b1 : v + 1'b1;
    end
    return r;
  endfunction

  bres_pkg::coord_t                       cur_x, cur_y;
  bres_pkg::coord_t                       major_delta, minor_delta;
  logic signed [bres_pkg::ERR_BITS-1:0]   error_term;
  logic [bres_pkg::CNT_BITS-1:0]          pixels_left;
  logic                                   steep_flag;
  logic [3:0]                             step_signs;

  bres_pkg::coord_t                       dx, dy, maj_next, min_next;
  logic [3:0]                             step_signs_next;
  logic                                   steep_next;
  logic signed [bres_pkg::ERR_BITS-1:0]   err_init, err_sub, err_next;
  logic                                   err_pos;

  // Set-up from the incoming endpoints
  always_comb begin
    dx = (line.x_end >= line.x_start) ? line.x_end - line.x_start
                                      : line.x_start - line.x_end;
    dy = (line.y_end >= line.y_start) ? line.y_end - line.y_start
                                      : line.y_start - line.y_end;
    step_signs_next = {line.y_end < line.y_start, line.y_end != line.y_start,
                       line.x_end < line.x_start, line.x_end != line.x_start};
    steep_next = dy > dx;
    maj_next   = steep_next ? dy : dx;
    min_next   = steep_next ? dx : dy;
    err_init   = $signed({2'b00, min_next, 1'b0}) - $signed({3'b000, maj_next});
  end

  // Decision step: a zero term leaves the minor axis alone
  always_comb begin
    err_pos  = !error_term[bres_pkg::ERR_BITS-1] && (|error_term);
    err_sub  = err_pos ? error_term - $signed({2'b00, major_delta, 1'b0}) : error_term;
    err_next = err_sub + $signed({2'b00, minor_delta, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x       <= line.x_start;
      cur_y       <= line.y_start;
      major_delta <= maj_next;
      minor_delta <= min_next;
      steep_flag  <= steep_next;
      step_signs  <= step_signs_next;
      error_term  <= err_init;
      pixels_left <= {1'b0, maj_next} + 1'b1;
    end else if (cmd.advance) begin
      if (steep_flag) begin
        cur_y <= axis_step(cur_y, step_signs[3:2]);
        if (err_pos) begin
          cur_x <= axis_step(cur_x, step_signs[1:0]);
        end
      end else begin
        cur_x <= axis_step(cur_x, step_signs[1:0]);
        if (err_pos) begin
          cur_y <= axis_step(cur_y, step_signs[3:2]);
        end
      end
      error_term  <= err_next;
      pixels_left <= pixels_left - 1'b1;
    end
  end

  assign status.last      = (pixels_left == bres_pkg::CNT_BITS'(1));
  assign pixel.pixel_x    = cur_x;
  assign pixel.pixel_y    = cur_y;
  assign pixel.last_pixel = status.last;

endmodule

// ----- rtl/bres_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bresenham controller
// Sequences line set-up and pixel transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bres_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  input  logic                 pixel_stall,
  input  bres_pkg::dp_status_t status,
  output logic                 line_stall,
  output logic                 pixel_valid,
  output bres_pkg::dp_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;
  logic   pixel_xfer;

  assign pixel_xfer  = pixel_valid && !pixel_stall;
  assign cmd.load    = line_valid && !line_stall;
  // Advance only between pixels of the same line
  assign cmd.advance = pixel_xfer && !status.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      line_stall  <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            state       <= RUN;
            line_stall  <= 1'b1;
            pixel_valid <= 1'b1;
          end
        end
        RUN: begin
          if (pixel_xfer && status.last) begin
            state       <= IDLE;
            line_stall  <= 1'b0;
            pixel_valid <= 1'b0;
          end
        end
        default: begin
          state       <= IDLE;
          line_stall  <= 1'b0;
          pixel_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bresenham_line_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer, top level
// Takes one line segment per transfer and emits each pixel from start to end.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  line    | line_valid/line_stall | x_start, y_start, x_end, y_end
//  pixel   | pixel_valid/pixel_st. | pixel_x, pixel_y, last_pixel
//
//  A line of major-axis length L gives L+1 pixels, up to 64 in all. The line
//  transfer loads the set-up; then one pixel per cycle while not stalled.
//  The datapath's single stepping unit paces it, one Bresenham step a cycle.
//  Reset (rst, synchronous) returns the controller to idle, no pixel pending.
//  pixel_stall holds the current pixel; line_stall is high while a line runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bresenham_line_rasterizer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             line_valid,
  output logic             line_stall,
  input  bres_pkg::line_t  line,
  output logic             pixel_valid,
  input  logic             pixel_stall,
  output bres_pkg::pixel_t pixel
);

  bres_pkg::dp_cmd_t    cmd;
  bres_pkg::dp_status_t status;

  // Controller: accept a line when idle, then hand out its pixels
  bres_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .line_valid  (line_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .line_stall  (line_stall),
    .pixel_valid (pixel_valid),
    .cmd         (cmd)
  );

  // Datapath: load the set-up on a line transfer, advance on each pixel
  // transfer that is not the final one
  bres_dp u_dp (
    .clk    (clk),
    .line   (line),
    .cmd    (cmd),
    .pixel  (pixel),
    .status (status)
  );

endmodule

// ----- rtl/bres_checker.sv -----
// ----------------------------------------------------------------------------
// Bresenham port checker
// Watches the top-level ports for sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_top_defines.svh"

module bres_checker (
  input logic             clk,
  input logic             rst,
  input logic             line_valid,
  input logic             line_stall,
  input bres_pkg::line_t  line,
  input logic             pixel_valid,
  input logic             pixel_stall,
  input bres_pkg::pixel_t pixel
);

  `BRES_ASSERT_ALWAYS(a_reset_quiet, rst |=> !pixel_valid, "pixel valid after reset")
  `BRES_ASSERT(a_busy_after_line, (line_valid && !line_stall) |=> (line_stall && pixel_valid), "line not started")
  `BRES_ASSERT(a_no_line_mid_draw, pixel_valid |-> line_stall, "line accepted mid draw")
  `BRES_ASSERT(a_last_ends_line, (pixel_valid && !pixel_stall && pixel.last_pixel) |=> !pixel_valid, "pixel after last")
  `BRES_ASSERT(a_stall_holds, (pixel_valid && pixel_stall) |=> (pixel_valid && $stable(pixel)), "stalled pixel changed")

endmodule

bind bresenham_line_rasterizer_top bres_checker u_bres_checker (
  .clk         (clk),
  .rst         (rst),
  .line_valid  (line_valid),
  .line_stall  (line_stall),
  .line        (line),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer testbench
// Sends line segments over the line channel and checks every pixel that
// comes back, in order, against a scoreboard that rasterises each accepted
// line itself. Both channels pause at random, with calm stretches between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_LINES = 150;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_LIMIT = 10;

  // Idle profiles for both sides of the block.
  typedef enum int {
    IDLE_NONE,
    IDLE_HEAVY,
    IDLE_LIGHT
  } idle_mode_t;

  // Expected pixel stream, one rasterised line after another.
  class raster_scoreboard;
    bres_pkg::pixel_t expected_pixels[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Move one unit towards the end point when that axis moves at all.
    function bres_pkg::coord_t nudge(bres_pkg::coord_t v, logic moves, logic down);
      if (!moves) return v;
      return down ? v - 1'b1 : v + 1'b1;
    endfunction

    // Work out every pixel of an accepted line and queue it.
    function void rasterise_line(bres_pkg::line_t seg);
      bres_pkg::coord_t dx, dy, major, minor, cx, cy;
      logic             steep, x_moves, x_down, y_moves, y_down;
      int               err;
      bres_pkg::pixel_t p;
      x_moves = seg.x_end != seg.x_start;
      x_down  = seg.x_end <  seg.x_start;
      y_moves = seg.y_end != seg.y_start;
      y_down  = seg.y_end <  seg.y_start;
      dx      = x_down ? seg.x_start - seg.x_end : seg.x_end - seg.x_start;
      dy      = y_down ? seg.y_start - seg.y_end : seg.y_end - seg.y_start;
      steep   = dy > dx;
      major   = steep ? dy : dx;
      minor   = steep ? dx : dy;
      cx      = seg.x_start;
      cy      = seg.y_start;
      err     = 2 * int'(minor) - int'(major);
      for (int i = 0; i <= int'(major); i++) begin
        p.pixel_x    = cx;
        p.pixel_y    = cy;
        p.last_pixel = (i == int'(major));
        expected_pixels.push_back(p);
        // A tie (error exactly zero) keeps the minor axis still.
        if (err > 0) begin
          if (steep) cx = nudge(cx, x_moves, x_down);
          else       cy = nudge(cy, y_moves, y_down);
          err -= 2 * int'(major);
        end
        if (steep) cy = nudge(cy, y_moves, y_down);
        else       cx = nudge(cx, x_moves, x_down);
        err += 2 * int'(minor);
      end
    endfunction

    function void check_pixel(bres_pkg::pixel_t got);
      bres_pkg::pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: pixel with none pending: x=%0d y=%0d last=%0b",
                   $realtime, got.pixel_x, got.pixel_y, got.last_pixel);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.last_pixel !== want.last_pixel) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   $realtime, want.pixel_x, want.pixel_y, want.last_pixel,
                   got.pixel_x, got.pixel_y, got.last_pixel);
      end
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             line_valid  = 1'b0;
  logic             line_stall;
  bres_pkg::line_t  line        = '0;
  logic             pixel_valid;
  logic             pixel_stall = 1'b0;
  bres_pkg::pixel_t pixel;

  raster_scoreboard board;
  idle_mode_t       idle_mode = IDLE_LIGHT;
  int unsigned      cycle_count = 0;

  bresenham_line_rasterizer_top dut (
    .clk         (clk),
    .rst         (rst),
    .line_valid  (line_valid),
    .line_stall  (line_stall),
    .line        (line),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

  always #5 clk = ~clk;

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bresenham_line_rasterizer_top verification failed");
      $finish;
    end
  end

  // Watch both channels at the rising edge; a transfer feeds the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (line_valid && !line_stall) board.rasterise_line(line);
      if (pixel_valid && !pixel_stall) board.check_pixel(pixel);
    end
  end

  function automatic int idle_draw();
    case (idle_mode)
      IDLE_NONE:  return 0;
      IDLE_HEAVY: return $urandom_range(0, 16);
      default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  function automatic bres_pkg::coord_t clip(int v);
    if (v < 0) return '0;
    if (v > (1 << bres_pkg::COORD_BITS) - 1) return '1;
    return bres_pkg::coord_t'(v);
  endfunction

  function automatic bres_pkg::line_t make_line(int x0, int y0, int x1, int y1);
    bres_pkg::line_t seg;
    seg.x_start = clip(x0);
    seg.y_start = clip(y0);
    seg.x_end   = clip(x1);
    seg.y_end   = clip(y1);
    return seg;
  endfunction

  // Mix of shapes: wide random, short, axis-aligned, diagonal, single point.
  function automatic bres_pkg::line_t random_line();
    bres_pkg::line_t  seg;
    bres_pkg::coord_t tmp;
    int               span, ox, oy;
    seg = bres_pkg::line_t'($urandom());
    case ($urandom_range(0, 5))
      0, 1: ;
      2: begin
        seg.x_end = clip(int'(seg.x_start) + $urandom_range(0, 14) - 7);
        seg.y_end = clip(int'(seg.y_start) + $urandom_range(0, 14) - 7);
      end
      3: begin
        if ($urandom_range(0, 1)) seg.y_end = seg.y_start;
        else                      seg.x_end = seg.x_start;
      end
      4: begin
        span = $urandom_range(0, (1 << bres_pkg::COORD_BITS) - 1);
        ox   = $urandom_range(0, (1 << bres_pkg::COORD_BITS) - 1 - span);
        oy   = $urandom_range(0, (1 << bres_pkg::COORD_BITS) - 1 - span);
        seg  = make_line(ox, oy, ox + span, oy + span);
        if ($urandom_range(0, 1)) begin
          seg.x_start = ~seg.x_start;
          seg.x_end   = ~seg.x_end;
        end
      end
      default: begin
        seg.x_end = seg.x_start;
        seg.y_end = seg.y_start;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      tmp = seg.x_start; seg.x_start = seg.x_end; seg.x_end = tmp;
      tmp = seg.y_start; seg.y_start = seg.y_end; seg.y_end = tmp;
    end
    return seg;
  endfunction

  // Enter and leave at a falling edge; with no gap, valid simply stays high.
  task automatic drive_line(bres_pkg::line_t seg);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    line       <= seg;
    line_valid <= 1'b1;
    do @(posedge clk); while (line_stall);
    @(negedge clk);
  endtask

  // Pixel side: hold off for a drawn number of cycles, then take one pixel.
  initial begin : pixel_sink
    int hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        pixel_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      pixel_stall <= 1'b0;
      do @(posedge clk); while (!pixel_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single points at both corners.
    drive_line(make_line(0, 0, 0, 0));
    drive_line(make_line(63, 63, 63, 63));
    // Full-length horizontal, vertical and diagonal lines, both directions.
    drive_line(make_line(0, 17, 63, 17));
    drive_line(make_line(63, 40, 0, 40));
    drive_line(make_line(5, 0, 5, 63));
    drive_line(make_line(58, 63, 58, 0));
    drive_line(make_line(0, 0, 63, 63));
    drive_line(make_line(63, 0, 0, 63));
    // One line per octant, out from the centre.
    drive_line(make_line(32, 32, 50, 40));
    drive_line(make_line(32, 32, 40, 50));
    drive_line(make_line(32, 32, 14, 40));
    drive_line(make_line(32, 32, 24, 50));
    drive_line(make_line(32, 32, 14, 24));
    drive_line(make_line(32, 32, 24, 14));
    drive_line(make_line(32, 32, 50, 24));
    drive_line(make_line(32, 32, 40, 14));
    // Ties in the decision term.
    drive_line(make_line(0, 0, 2, 1));
    drive_line(make_line(10, 10, 14, 12));
    drive_line(make_line(20, 30, 21, 28));
    // Longest shallow and steep lines with a one-unit minor span.
    drive_line(make_line(63, 0, 0, 1));
    drive_line(make_line(0, 63, 1, 0));

    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i % 25 == 0) idle_mode = idle_mode_t'($urandom_range(0, 2));
      drive_line(random_line());
    end
    line_valid <= 1'b0;

    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.expected_pixels.size() == 0)
      $display("bresenham_line_rasterizer_top verification clean");
    else
      $display("bresenham_line_rasterizer_top verification failed");
    $finish;
  end

endmodule
